// ===== src/session_log_flash_writer_assert.svh =====
// Assertion macros for the session log flash writer.
// Users must have i_clk and i_rst_n (sync, active low) in scope.
`ifndef SESSION_LOG_FLASH_WRITER_ASSERT_SVH
`define SESSION_LOG_FLASH_WRITER_ASSERT_SVH

// same-cycle implication
`define SLFW_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLFW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/slfw_pkg.sv =====
// Shared codes, constants and types of the session log flash writer.
// No dependencies.
package slfw_pkg;

    // action codes
    localparam logic [2:0] ACT_RESET = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_CLOSE = 3'd2;
    localparam logic [2:0] ACT_ADD   = 3'd3;
    localparam logic [2:0] ACT_WRITE = 3'd4;
    localparam logic [2:0] ACT_ERASE = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_ERASE  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_LOG_MODE     = 2'd0;
    localparam logic [1:0] CFG_LOG_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_WR_THRESH    = 2'd2;

    localparam logic [15:0] START_MARKER = 16'hFFFB;
    localparam logic [15:0] END_MARKER   = 16'hFFFE;
    localparam int          HDR_LEN      = 11;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_buf_ctl;

endpackage

// ===== src/slfw_buf.sv =====
// Byte buffer of the session log flash writer: even and odd byte banks,
// one write port, one registered read of a full word row. Uses slfw_pkg.
module slfw_buf #(
    parameter int BUFFER_BYTES = 64,
    localparam int IW = $clog2(BUFFER_BYTES),
    localparam int RW = IW - 1,
    localparam int BD = (BUFFER_BYTES + 1) / 2
) (
    input  logic               i_clk,
    input  slfw_pkg::t_buf_ctl i_ctl,
    input  logic [IW-1:0]      i_wr_idx,
    input  logic [7:0]         i_wr_data,
    input  logic [RW-1:0]      i_rd_row,
    output logic [7:0]         o_rd_even,
    output logic [7:0]         o_rd_odd
);
    logic [7:0] r_even [BD];
    logic [7:0] r_odd  [BD];
    logic [7:0] r_rd_even;
    logic [7:0] r_rd_odd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            if (i_wr_idx[0]) begin
                r_odd[i_wr_idx[IW-1:1]] <= i_wr_data;
            end else begin
                r_even[i_wr_idx[IW-1:1]] <= i_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_even <= r_even[i_rd_row];
            r_rd_odd  <= r_odd[i_rd_row];
        end
    end

    assign o_rd_even = r_rd_even;
    assign o_rd_odd  = r_rd_odd;

endmodule

// ===== src/slfw_ctrl.sv =====
// Sequencer of the session log flash writer: header fill, byte push,
// flush walk with end-of-memory cut, page erase. Uses slfw_pkg and session_log_flash_writer_assert.svh.
`include "session_log_flash_writer_assert.svh"
module slfw_ctrl #(
    parameter int BUFFER_BYTES = 64,
    parameter int MEM_START    = 24576,
    parameter int MEM_END      = 32768,
    parameter int PAGE_COUNT   = 16,
    localparam int FW = $clog2(BUFFER_BYTES + 1),
    localparam int IW = $clog2(BUFFER_BYTES),
    localparam int RW = IW - 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [2:0]         i_action,
    input  logic [7:0]         i_data_byte,
    input  logic [4:0]         i_day,
    input  logic [3:0]         i_month,
    input  logic [15:0]        i_year,
    input  logic [4:0]         i_hour,
    input  logic [5:0]         i_minute,
    input  logic [5:0]         i_second,
    input  logic               i_write_window_ok,
    input  logic [7:0]         i_log_mode,
    input  logic [7:0]         i_log_interval,
    input  logic [6:0]         i_write_threshold,
    output logic               o_busy,
    output slfw_pkg::t_buf_ctl o_buf_ctl,
    output logic [IW-1:0]      o_wr_idx,
    output logic [7:0]         o_wr_data,
    output logic [RW-1:0]      o_rd_row,
    input  logic [7:0]         i_rd_even,
    input  logic [7:0]         i_rd_odd,
    output logic               o_strobe,
    output logic [1:0]         o_kind,
    output logic [15:0]        o_address,
    output logic [15:0]        o_word,
    output logic [3:0]         o_page_index,
    output logic               o_logging_on,
    output logic               o_log_full,
    output logic               o_last
);
    import slfw_pkg::*;

    localparam logic [15:0]   LAST_ADDR  = 16'(MEM_END - 1);
    localparam logic [15:0]   START_ADDR = 16'(MEM_START);
    localparam logic [FW-1:0] BUF_SIZE   = FW'(BUFFER_BYTES);
    localparam logic [FW-1:0] PUSH_PAD   = FW'(0);
    localparam logic [FW-1:0] PUSH_LO    = FW'(1);
    localparam logic [FW-1:0] PUSH_HI    = FW'(2);

    typedef enum logic [3:0] {
        S_IDLE, S_ERASE, S_HDR, S_PUSH, S_FCHK, S_FRD, S_FWAIT, S_FEND, S_CARRY
    } t_state;

    t_state        r_state, n_state;
    logic [FW-1:0] r_cnt, n_cnt;
    logic [FW-1:0] r_fill, n_fill;
    logic [FW-1:0] r_words, n_words;
    logic [15:0]   r_wa, n_wa;
    logic          r_active, n_active;
    logic          r_full, n_full;
    logic          r_eom, n_eom;
    logic          r_p1_valid, n_p1_valid;
    logic [15:0]   r_p1_addr, n_p1_addr;
    logic          r_p1_last, n_p1_last;
    logic [4:0]    r_day;
    logic [3:0]    r_month;
    logic [15:0]   r_year;
    logic [4:0]    r_hour;
    logic [5:0]    r_minute;
    logic [5:0]    r_second;
    logic          r_strobe, n_strobe;
    logic [1:0]    r_kind, n_kind;
    logic [15:0]   r_addr, n_addr;
    logic [15:0]   r_word, n_word;
    logic [3:0]    r_page, n_page;
    logic          r_log_on;
    logic          r_mem_full;
    logic          r_last, n_last;

    logic          can;
    logic          st_emit;
    logic          capture;
    logic          last_word;
    logic          eom;
    logic [16:0]   end_sum;
    logic [15:0]   rem;
    logic [FW-1:0] fill_cut;
    logic [FW-1:0] fill_m1;
    logic [7:0]    push_byte;

    function automatic logic [7:0] hdr_byte(input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = START_MARKER[7:0];
            4'd1:    b = START_MARKER[15:8];
            4'd2:    b = i_log_mode;
            4'd3:    b = i_log_interval;
            4'd4:    b = 8'(r_day);
            4'd5:    b = 8'(r_month);
            4'd6:    b = r_year[7:0];
            4'd7:    b = r_year[15:8];
            4'd8:    b = 8'(r_hour);
            4'd9:    b = 8'(r_minute);
            4'd10:   b = 8'(r_second);
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // end-of-memory check for the flush setup
    assign end_sum  = {1'b0, r_wa} + 17'(r_fill);
    assign eom      = end_sum >= {1'b0, LAST_ADDR};
    assign rem      = (r_wa <= LAST_ADDR) ? (LAST_ADDR - r_wa) : 16'd0;
    assign fill_cut = eom ? rem[FW-1:0] : r_fill;
    assign fill_m1  = r_fill - FW'(1);

    assign can       = r_active && !r_full;
    assign last_word = (r_cnt == r_words - FW'(1));

    always_comb begin
        unique case (r_cnt)
            PUSH_PAD: push_byte = 8'h00;
            PUSH_LO:  push_byte = END_MARKER[7:0];
            default:  push_byte = END_MARKER[15:8];
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_fill     = r_fill;
        n_words    = r_words;
        n_wa       = r_wa;
        n_active   = r_active;
        n_full     = r_full;
        n_eom      = r_eom;
        n_p1_valid = 1'b0;
        n_p1_addr  = r_p1_addr;
        n_p1_last  = r_p1_last;
        n_strobe   = 1'b0;
        n_kind     = KIND_STATUS;
        n_addr     = '0;
        n_word     = '0;
        n_page     = '0;
        n_last     = 1'b0;
        o_buf_ctl  = '0;
        o_wr_idx   = '0;
        o_wr_data  = '0;
        o_rd_row   = '0;
        st_emit    = 1'b0;
        capture    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_action)
                        ACT_RESET: begin
                            n_active = 1'b0;
                            n_full   = 1'b0;
                            n_wa     = START_ADDR;
                            n_fill   = '0;
                            n_cnt    = '0;
                            n_state  = S_ERASE;
                        end
                        ACT_START: begin
                            if (!r_active && !r_full) begin
                                n_fill   = '0;
                                n_active = 1'b1;
                                n_cnt    = '0;
                                capture  = 1'b1;
                                n_state  = S_HDR;
                            end else begin
                                st_emit = 1'b1;
                            end
                        end
                        ACT_CLOSE: begin
                            n_active = 1'b0;
                            if (can) begin
                                n_cnt   = r_fill[0] ? PUSH_PAD : PUSH_LO;
                                n_state = S_PUSH;
                            end else begin
                                st_emit = 1'b1;
                            end
                        end
                        ACT_ADD: begin
                            if (can && r_fill < BUF_SIZE) begin
                                o_buf_ctl.wr_en = 1'b1;
                                o_wr_idx        = r_fill[IW-1:0];
                                o_wr_data       = i_data_byte;
                                n_fill          = r_fill + FW'(1);
                            end
                            st_emit = 1'b1;
                        end
                        ACT_WRITE: begin
                            if (can && (8'(r_fill) > 8'(i_write_threshold))
                                    && i_write_window_ok) begin
                                n_state = S_FCHK;
                            end else begin
                                st_emit = 1'b1;
                            end
                        end
                        ACT_ERASE: begin
                            if (!r_active) begin
                                n_cnt   = '0;
                                n_state = S_ERASE;
                            end else begin
                                st_emit = 1'b1;
                            end
                        end
                        default: st_emit = 1'b1;
                    endcase
                end
            end
            S_ERASE: begin
                n_strobe = 1'b1;
                n_kind   = KIND_ERASE;
                n_page   = r_cnt[3:0];
                if (r_cnt == FW'(PAGE_COUNT - 1)) begin
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + FW'(1);
                end
            end
            S_HDR: begin
                o_buf_ctl.wr_en = 1'b1;
                o_wr_idx        = r_cnt[IW-1:0];
                o_wr_data       = hdr_byte(r_cnt[3:0]);
                n_fill          = r_cnt + FW'(1);
                if (r_cnt == FW'(HDR_LEN - 1)) begin
                    st_emit = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + FW'(1);
                end
            end
            S_PUSH: begin
                if (r_fill < BUF_SIZE) begin
                    o_buf_ctl.wr_en = 1'b1;
                    o_wr_idx        = r_fill[IW-1:0];
                    o_wr_data       = push_byte;
                    n_fill          = r_fill + FW'(1);
                end
                if (r_cnt == PUSH_HI) begin
                    n_state = S_FCHK;
                end else begin
                    n_cnt = r_cnt + FW'(1);
                end
            end
            S_FCHK: begin
                n_eom   = eom;
                n_fill  = fill_cut;
                n_words = fill_cut >> 1;
                n_cnt   = '0;
                if (eom) begin
                    n_active = 1'b0;
                    n_full   = 1'b1;
                end
                n_state = (fill_cut[FW-1:1] != '0) ? S_FRD : S_FEND;
            end
            S_FRD: begin
                o_buf_ctl.rd_en = 1'b1;
                o_rd_row        = r_cnt[RW-1:0];
                n_p1_valid      = 1'b1;
                n_p1_addr       = r_wa;
                n_p1_last       = last_word && !r_eom;
                n_wa            = r_wa + 16'd2;
                if (last_word) begin
                    n_state = S_FWAIT;
                end else begin
                    n_cnt = r_cnt + FW'(1);
                end
            end
            S_FWAIT: n_state = S_FEND;
            S_FEND: begin
                if (r_eom) begin
                    n_strobe = 1'b1;
                    n_kind   = KIND_WRITE;
                    n_addr   = LAST_ADDR;
                    n_word   = END_MARKER;
                    n_last   = 1'b1;
                    n_fill   = '0;
                    n_state  = S_IDLE;
                end else if (r_fill[0]) begin
                    o_buf_ctl.rd_en = 1'b1;
                    o_rd_row        = fill_m1[RW:1];
                    n_state         = S_CARRY;
                end else begin
                    n_fill  = '0;
                    st_emit = (r_words == '0);
                    n_state = S_IDLE;
                end
            end
            S_CARRY: begin
                // odd trailing byte moves to the front
                o_buf_ctl.wr_en = 1'b1;
                o_wr_idx        = '0;
                o_wr_data       = i_rd_even;
                n_fill          = FW'(1);
                st_emit         = (r_words == '0);
                n_state         = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (r_p1_valid) begin
            n_strobe = 1'b1;
            n_kind   = KIND_WRITE;
            n_addr   = r_p1_addr;
            n_word   = {i_rd_odd, i_rd_even};
            n_last   = r_p1_last;
        end
        if (st_emit) begin
            n_strobe = 1'b1;
            n_kind   = KIND_STATUS;
            n_last   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_fill     <= '0;
            r_words    <= '0;
            r_wa       <= START_ADDR;
            r_active   <= 1'b0;
            r_full     <= 1'b0;
            r_eom      <= 1'b0;
            r_p1_valid <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_fill     <= n_fill;
            r_words    <= n_words;
            r_wa       <= n_wa;
            r_active   <= n_active;
            r_full     <= n_full;
            r_eom      <= n_eom;
            r_p1_valid <= n_p1_valid;
            r_strobe   <= n_strobe;
        end
        r_p1_addr  <= n_p1_addr;
        r_p1_last  <= n_p1_last;
        r_kind     <= n_kind;
        r_addr     <= n_addr;
        r_word     <= n_word;
        r_page     <= n_page;
        r_log_on   <= n_active;
        r_mem_full <= n_full;
        r_last     <= n_last;
        if (capture) begin
            r_day    <= i_day;
            r_month  <= i_month;
            r_year   <= i_year;
            r_hour   <= i_hour;
            r_minute <= i_minute;
            r_second <= i_second;
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_kind        = r_kind;
    assign o_address     = r_addr;
    assign o_word        = r_word;
    assign o_page_index  = r_page;
    assign o_logging_on  = r_log_on;
    assign o_log_full    = r_mem_full;
    assign o_last        = r_last;

    `SLFW_ASSERT(a_last_ends_step, r_strobe && r_last, r_state == S_IDLE || r_state == S_FEND, "last result mid-flush")
    `SLFW_ASSERT(a_fill_bound, 1'b1, r_fill <= BUF_SIZE, "fill count beyond buffer size")
    `SLFW_ASSERT(a_word_in_flush, r_p1_valid, r_state == S_FRD || r_state == S_FWAIT, "stray word read")
    `SLFW_ASSERT_NEXT(a_accept_acts, i_start && !o_busy, r_strobe || r_state != S_IDLE, "accepted item dropped")

endmodule

// ===== src/session_log_flash_writer.sv =====
// A step without flash work gives its status result in the cycle after the transfer.
// Erase/reset: one erase request per page, one per cycle. Start: fills the 11-byte header.
// Flush: up to 3 pushed bytes on close, a setup step, then one row read per cycle; each
// word goes through the buffer read register and the output register to the ports.
// Throughput: one item at a time, next transfer once busy drops; receiver cannot stall.
// Reset (i_rst_n low, sync): flags, fill, write pointer and config return to defaults.
module session_log_flash_writer #(
    parameter int BUFFER_BYTES = 64,
    parameter int MEM_START    = 24576,
    parameter int MEM_END      = 32768,
    parameter int PAGE_COUNT   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_data_byte,
    input  logic [4:0]  i_day,
    input  logic [3:0]  i_month,
    input  logic [15:0] i_year,
    input  logic [4:0]  i_hour,
    input  logic [5:0]  i_minute,
    input  logic [5:0]  i_second,
    input  logic        i_write_window_ok,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    output logic        busy,
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic [15:0] o_address,
    output logic [15:0] o_word,
    output logic [3:0]  o_page_index,
    output logic        o_logging_on,
    output logic        o_log_full,
    output logic        o_last
);
    import slfw_pkg::*;

    localparam int IW = $clog2(BUFFER_BYTES);
    localparam int RW = IW - 1;

    logic [7:0]    r_log_mode;
    logic [7:0]    r_log_interval;
    logic [6:0]    r_wr_thresh;
    t_buf_ctl      buf_ctl;
    logic [IW-1:0] wr_idx;
    logic [7:0]    wr_data;
    logic [RW-1:0] rd_row;
    logic [7:0]    rd_even;
    logic [7:0]    rd_odd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_mode     <= 8'd0;
            r_log_interval <= 8'd1;
            r_wr_thresh    <= 7'd32;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LOG_MODE:     r_log_mode     <= i_cfg_data;
                CFG_LOG_INTERVAL: r_log_interval <= i_cfg_data;
                CFG_WR_THRESH:    r_wr_thresh    <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    slfw_buf #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_buf (
        .i_clk     (i_clk),
        .i_ctl     (buf_ctl),
        .i_wr_idx  (wr_idx),
        .i_wr_data (wr_data),
        .i_rd_row  (rd_row),
        .o_rd_even (rd_even),
        .o_rd_odd  (rd_odd)
    );

    slfw_ctrl #(
        .BUFFER_BYTES(BUFFER_BYTES),
        .MEM_START   (MEM_START),
        .MEM_END     (MEM_END),
        .PAGE_COUNT  (PAGE_COUNT)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_action          (i_action),
        .i_data_byte       (i_data_byte),
        .i_day             (i_day),
        .i_month           (i_month),
        .i_year            (i_year),
        .i_hour            (i_hour),
        .i_minute          (i_minute),
        .i_second          (i_second),
        .i_write_window_ok (i_write_window_ok),
        .i_log_mode        (r_log_mode),
        .i_log_interval    (r_log_interval),
        .i_write_threshold (r_wr_thresh),
        .o_busy            (busy),
        .o_buf_ctl         (buf_ctl),
        .o_wr_idx          (wr_idx),
        .o_wr_data         (wr_data),
        .o_rd_row          (rd_row),
        .i_rd_even         (rd_even),
        .i_rd_odd          (rd_odd),
        .o_strobe          (o_strobe),
        .o_kind            (o_kind),
        .o_address         (o_address),
        .o_word            (o_word),
        .o_page_index      (o_page_index),
        .o_logging_on      (o_logging_on),
        .o_log_full        (o_log_full),
        .o_last            (o_last)
    );

endmodule
